>>> design/tsfbc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsfbc_pkg
// Shared types and constants for the two-stage feedback byte cipher.
// ---------------------------------------------------------------------------
package tsfbc_pkg;

   localparam int unsigned KEY_W  = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned ADDR_W = 5;
   localparam int unsigned DATA_W = 32;

   // register reset values
   localparam logic [KEY_W-1:0] FIRST_MUL_RST  = 16'hCE6D;
   localparam logic [KEY_W-1:0] FIRST_ADD_RST  = 16'h58BF;
   localparam logic [KEY_W-1:0] SECOND_MUL_RST = 16'h310F;
   localparam logic [KEY_W-1:0] SECOND_ADD_RST = 16'h3A4E;

   // key derivation offsets at message start
   localparam logic [KEY_W-1:0] FIRST_SEED_OFS  = 16'h000C;
   localparam logic [KEY_W-1:0] SECOND_SEED_OFS = 16'h000B;

   // register index (byte address / 4)
   typedef enum logic [2:0] {
      REG_SEED_WORD   = 3'd0,
      REG_SEED_BYTE   = 3'd1,
      REG_DECODE_MODE = 3'd2,
      REG_FIRST_MUL   = 3'd3,
      REG_FIRST_ADD   = 3'd4,
      REG_SECOND_MUL  = 3'd5,
      REG_SECOND_ADD  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [KEY_W-1:0]  seed_word;
      logic [BYTE_W-1:0] seed_byte;
      logic              decode_mode;
      logic [KEY_W-1:0]  first_mul;
      logic [KEY_W-1:0]  first_add;
      logic [KEY_W-1:0]  second_mul;
      logic [KEY_W-1:0]  second_add;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0] first_key;
      logic [KEY_W-1:0] second_key;
   } keys_type;

endpackage

>>> design/tsfbc_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsfbc_csr
// APB-style register file holding seeds, mode and key update constants.
// ---------------------------------------------------------------------------
module tsfbc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tsfbc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [tsfbc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [tsfbc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                          csr_pready,
   output tsfbc_pkg::cfg_type            cfg
);

   tsfbc_pkg::cfg_type       cfg_ff;
   tsfbc_pkg::reg_index_type idx;
   logic                     wr_en;

   assign idx        = tsfbc_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed_word   <= '0;
         cfg_ff.seed_byte   <= '0;
         cfg_ff.decode_mode <= 1'b0;
         cfg_ff.first_mul   <= tsfbc_pkg::FIRST_MUL_RST;
         cfg_ff.first_add   <= tsfbc_pkg::FIRST_ADD_RST;
         cfg_ff.second_mul  <= tsfbc_pkg::SECOND_MUL_RST;
         cfg_ff.second_add  <= tsfbc_pkg::SECOND_ADD_RST;
      end else if (wr_en) begin
         case (idx)
            tsfbc_pkg::REG_SEED_WORD:   cfg_ff.seed_word   <= csr_pwdata[15:0];
            tsfbc_pkg::REG_SEED_BYTE:   cfg_ff.seed_byte   <= csr_pwdata[7:0];
            tsfbc_pkg::REG_DECODE_MODE: cfg_ff.decode_mode <= csr_pwdata[0];
            tsfbc_pkg::REG_FIRST_MUL:   cfg_ff.first_mul   <= csr_pwdata[15:0];
            tsfbc_pkg::REG_FIRST_ADD:   cfg_ff.first_add   <= csr_pwdata[15:0];
            tsfbc_pkg::REG_SECOND_MUL:  cfg_ff.second_mul  <= csr_pwdata[15:0];
            tsfbc_pkg::REG_SECOND_ADD:  cfg_ff.second_add  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (idx)
         tsfbc_pkg::REG_SEED_WORD:   csr_prdata[15:0] = cfg_ff.seed_word;
         tsfbc_pkg::REG_SEED_BYTE:   csr_prdata[7:0]  = cfg_ff.seed_byte;
         tsfbc_pkg::REG_DECODE_MODE: csr_prdata[0]    = cfg_ff.decode_mode;
         tsfbc_pkg::REG_FIRST_MUL:   csr_prdata[15:0] = cfg_ff.first_mul;
         tsfbc_pkg::REG_FIRST_ADD:   csr_prdata[15:0] = cfg_ff.first_add;
         tsfbc_pkg::REG_SECOND_MUL:  csr_prdata[15:0] = cfg_ff.second_mul;
         tsfbc_pkg::REG_SECOND_ADD:  csr_prdata[15:0] = cfg_ff.second_add;
         default: ;
      endcase
   end

endmodule

>>> design/tsfbc_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsfbc_core
// Single-pass datapath: both XOR stages and both key updates for one byte.
// ---------------------------------------------------------------------------
module tsfbc_core (
   input  tsfbc_pkg::cfg_type                cfg,
   input  logic                              in_message,
   input  tsfbc_pkg::keys_type               keys,
   input  logic [tsfbc_pkg::BYTE_W-1:0]      data_byte,
   output logic [tsfbc_pkg::BYTE_W-1:0]      result_byte,
   output tsfbc_pkg::keys_type               keys_next
);

   logic [tsfbc_pkg::KEY_W-1:0]  k1, k2;
   logic [tsfbc_pkg::BYTE_W-1:0] mid, c1, c2;
   logic [tsfbc_pkg::KEY_W-1:0]  sum1, sum2;

   // message start: keys come from the seeds
   always_comb begin
      if (in_message) begin
         k1 = keys.first_key;
         k2 = keys.second_key;
      end else begin
         k1 = cfg.seed_word + tsfbc_pkg::FIRST_SEED_OFS;
         k2 = cfg.seed_word - {8'd0, cfg.seed_byte} + tsfbc_pkg::SECOND_SEED_OFS;
      end
   end

   always_comb begin
      if (cfg.decode_mode) begin
         mid         = data_byte ^ k2[15:8];
         result_byte = mid ^ k1[15:8];
         c2          = data_byte;
         c1          = mid;
      end else begin
         mid         = data_byte ^ k1[15:8];
         result_byte = mid ^ k2[15:8];
         c1          = mid;
         c2          = result_byte;
      end
   end

   // key update, mod 2^16 throughout
   assign sum1 = k1 + {8'd0, c1};
   assign sum2 = k2 + {8'd0, c2};
   assign keys_next.first_key  = sum1 * cfg.first_mul + cfg.first_add;
   assign keys_next.second_key = sum2 * cfg.second_mul + cfg.second_add;

endmodule

>>> design/two_stage_feedback_byte_cipher_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_stage_feedback_byte_cipher_top
// Byte stream cipher with two cascaded 16-bit key-feedback stages.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one byte per beat, req_tlast closes a message. rsp_*
//    returns one byte per beat with rsp_tlast copied from the request.
//  - csr_* is an APB-style port; register i at byte address 4*i. Write
//    registers only while no beats are in flight.
//  - A beat is taken into an input register; both stages and both key
//    updates then run combinationally and the result lands in the output
//    register, which drives rsp_tvalid. A response can thus be taken only
//    after its beat has passed through both registers.
//  - Throughput is one beat per cycle while rsp_tready is high; the limit
//    is the key feedback loop (add, 16x16 multiply, add) via key registers.
//  - The first beat of every message loads the keys from seed_word and
//    seed_byte; the beat after a tlast beat starts a new message.
//  - If rsp_tready is low the output register holds, the input register
//    fills, and req_tready drops; nothing is lost.
//  - Synchronous reset empties both registers, clears the keys and the
//    message flag, and restores the register defaults.
// ---------------------------------------------------------------------------
module two_stage_feedback_byte_cipher_top (
   input  logic        clock,
   input  logic        reset,
   // request: tdata[7:0] = data_byte; tlast = last_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // response: tdata[7:0] = result_byte; tlast = result_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   tsfbc_pkg::cfg_type  cfg;
   tsfbc_pkg::keys_type keys_ff, keys_in;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_last_ff;

   // output register
   logic       out_valid_ff;
   logic [7:0] out_data_ff, out_data_in;
   logic       out_last_ff;

   logic       in_message_ff;
   logic       advance;   // input register moves to output register
   logic       req_take;

   tsfbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsfbc_core u_core (
      .cfg         (cfg),
      .in_message  (in_message_ff),
      .keys        (keys_ff),
      .data_byte   (in_data_ff),
      .result_byte (out_data_in),
      .keys_next   (keys_in)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
         out_last_ff <= in_last_ff;
      end
   end

   // key state moves with each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff       <= '0;
         in_message_ff <= 1'b0;
      end else if (advance) begin
         keys_ff       <= keys_in;
         in_message_ff <= !in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_last_ends_msg: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> !in_message_ff)
      else $error("message flag still set after last beat");

   a_beat_opens_msg: assert property (@(posedge clock) disable iff (reset)
      advance && !in_last_ff |=> in_message_ff)
      else $error("message flag clear after a non-last beat");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input register but request not ready");

   a_keys_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(keys_ff))
      else $error("keys changed without a processed beat");

endmodule

>>> dv/tsfbc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsfbc_checker
// Watches the request, response and register ports of the byte cipher. It
// keeps its own copy of the registers and both stage keys, predicts the
// response to every request beat and compares responses in order.
// ---------------------------------------------------------------------------
module tsfbc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          error_count,
   output int          pending_count,
   output int          checked_count
);

   typedef struct packed {
      logic [tsfbc_pkg::BYTE_W-1:0] data;
      logic                         last;
   } cipher_beat_type;

   tsfbc_pkg::cfg_type  regs;
   tsfbc_pkg::keys_type keys;
   logic                in_message;
   cipher_beat_type     cipher_q[$];
   int                  errors;
   int                  checked;

   initial begin
      errors  = 0;
      checked = 0;
   end

   function automatic logic [tsfbc_pkg::KEY_W-1:0] stepped_key(
         logic [tsfbc_pkg::KEY_W-1:0]  key,
         logic [tsfbc_pkg::BYTE_W-1:0] cbyte,
         logic [tsfbc_pkg::KEY_W-1:0]  mul,
         logic [tsfbc_pkg::KEY_W-1:0]  add);
      logic [tsfbc_pkg::KEY_W-1:0] sum;
      sum = key + tsfbc_pkg::KEY_W'(cbyte);
      return sum * mul + add;
   endfunction

   // runs both stages on one byte and advances the keys
   function automatic cipher_beat_type cipher_byte(logic [tsfbc_pkg::BYTE_W-1:0] x,
                                                   logic last);
      logic [tsfbc_pkg::BYTE_W-1:0] mid;
      logic [tsfbc_pkg::BYTE_W-1:0] y;
      if (!in_message) begin
         keys.first_key  = regs.seed_word + tsfbc_pkg::FIRST_SEED_OFS;
         keys.second_key = regs.seed_word - tsfbc_pkg::KEY_W'(regs.seed_byte)
                           + tsfbc_pkg::SECOND_SEED_OFS;
      end
      if (!regs.decode_mode) begin
         mid             = x ^ keys.first_key[15:8];
         keys.first_key  = stepped_key(keys.first_key, mid, regs.first_mul, regs.first_add);
         y               = mid ^ keys.second_key[15:8];
         keys.second_key = stepped_key(keys.second_key, y, regs.second_mul,
                                       regs.second_add);
      end else begin
         mid             = x ^ keys.second_key[15:8];
         keys.second_key = stepped_key(keys.second_key, x, regs.second_mul,
                                       regs.second_add);
         y               = mid ^ keys.first_key[15:8];
         keys.first_key  = stepped_key(keys.first_key, mid, regs.first_mul, regs.first_add);
      end
      in_message = !last;
      return '{data: y, last: last};
   endfunction

   always @(posedge clock) begin
      cipher_beat_type want;
      if (reset) begin
         regs = '{seed_word: '0, seed_byte: '0, decode_mode: 1'b0,
                  first_mul: tsfbc_pkg::FIRST_MUL_RST,
                  first_add: tsfbc_pkg::FIRST_ADD_RST,
                  second_mul: tsfbc_pkg::SECOND_MUL_RST,
                  second_add: tsfbc_pkg::SECOND_ADD_RST};
         keys       = '0;
         in_message = 1'b0;
         cipher_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               tsfbc_pkg::REG_SEED_WORD:   regs.seed_word   = csr_pwdata[15:0];
               tsfbc_pkg::REG_SEED_BYTE:   regs.seed_byte   = csr_pwdata[7:0];
               tsfbc_pkg::REG_DECODE_MODE: regs.decode_mode = csr_pwdata[0];
               tsfbc_pkg::REG_FIRST_MUL:   regs.first_mul   = csr_pwdata[15:0];
               tsfbc_pkg::REG_FIRST_ADD:   regs.first_add   = csr_pwdata[15:0];
               tsfbc_pkg::REG_SECOND_MUL:  regs.second_mul  = csr_pwdata[15:0];
               tsfbc_pkg::REG_SECOND_ADD:  regs.second_add  = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            cipher_q.push_back(cipher_byte(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response beat: data %02h last %0b",
                           rsp_tdata, rsp_tlast);
            end else begin
               want = cipher_q.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display({"response %0d mismatch: expected data %02h last %0b,",
                               " got data %02h last %0b"},
                              checked, want.data, want.last, rsp_tdata, rsp_tlast);
               end
               checked++;
            end
         end
      end
      error_count   <= errors;
      pending_count <= cipher_q.size();
      checked_count <= checked;
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-stage feedback byte cipher. Directed
// beats first (field extremes, single-byte messages, register writes inside
// an open message, unmapped address), then random messages over many random
// register settings, with sender and receiver idling and a long receiver
// hold-off. A separate checker predicts and compares every response.
// ---------------------------------------------------------------------------
module tb;

   // beat latency through the block, plus margin for the settle pauses
   localparam int unsigned PIPE_LAT      = 2;
   // index 7 decodes to no register: writes there must change nothing
   localparam logic [4:0]  UNMAPPED_ADDR = 5'd28;
   localparam int unsigned HOLD_OFF_LEN  = 48;
   localparam int unsigned N_PHASES      = 9;
   localparam int unsigned PHASE_BEATS   = 60;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] result_byte
   logic        rsp_tlast;   // result_last
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int error_count;
   int pending_count;
   int checked_count;

   // idle percentages for each side; hold-off requests from the sender and
   // the receiver's own countdown
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_requests;
   int hold_off_left;

   int beats_sent;
   int messages_sent;
   int settings_used;

   two_stage_feedback_byte_cipher_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tsfbc_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: ends a run that has not finished by then with FAILURE.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Receiver: random backpressure, except while a hold-off is counting down.
   // The hold-off is requested by the sender process and counted here.
   initial begin
      int hold_served;
      hold_served   = 0;
      hold_off_left = 0;
      rsp_tready    = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served   = hold_requests;
            hold_off_left = HOLD_OFF_LEN;
         end
         if (hold_off_left > 0) begin
            rsp_tready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [4:0] reg_addr(tsfbc_pkg::reg_index_type idx);
      return {idx, 2'b00};
   endfunction

   // Register write: setup and access phases, then the bus returns to idle.
   // Only ever called with the block idle.
   task automatic csr_write(logic [4:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one beat, with a random gap first; returns at the accepting edge
   // with tvalid still high so the next beat can follow back to back.
   task automatic send_beat(logic [7:0] data, logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      if (last) messages_sent++;
   endtask

   // Waits until every predicted response has been checked, then lets the
   // pipe settle. Called at the edge that accepted the last beat.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_LAT + 2) @(posedge clock);
   endtask

   // Random key parameter, biased toward the extremes.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic random_settings;
      logic [7:0] sbyte;
      sbyte = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
      csr_write(reg_addr(tsfbc_pkg::REG_SEED_WORD),   {16'h0, pick_word()});
      csr_write(reg_addr(tsfbc_pkg::REG_SEED_BYTE),   {24'h0, sbyte});
      csr_write(reg_addr(tsfbc_pkg::REG_DECODE_MODE), {31'h0, 1'($urandom_range(0, 1))});
      csr_write(reg_addr(tsfbc_pkg::REG_FIRST_MUL),   {16'h0, pick_word()});
      csr_write(reg_addr(tsfbc_pkg::REG_FIRST_ADD),   {16'h0, pick_word()});
      csr_write(reg_addr(tsfbc_pkg::REG_SECOND_MUL),  {16'h0, pick_word()});
      csr_write(reg_addr(tsfbc_pkg::REG_SECOND_ADD),  {16'h0, pick_word()});
      settings_used++;
   endtask

   initial begin
      int phase_beats;
      int hold_at;
      int msg_len;
      bit close_msg;

      // everything known from time zero
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_idle_pct  = 12;
      rsp_idle_pct  = 58;
      hold_requests = 0;
      beats_sent    = 0;
      messages_sent = 0;
      settings_used = 1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset settings, seeds zero, encode ---
      // single-byte messages at both byte extremes
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      // short message across the byte extremes and alternating bit patterns
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h55, 1'b0);
      send_beat(8'hAA, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(8'h80, 1'b1);
      // open a message and leave it open across register writes: the new
      // seeds must wait for the next message, mode and key params apply now
      send_beat(8'h3C, 1'b0);
      send_beat(8'hC3, 1'b0);
      drain();
      csr_write(reg_addr(tsfbc_pkg::REG_SEED_WORD),   32'h0000_FFFF);
      csr_write(reg_addr(tsfbc_pkg::REG_SEED_BYTE),   32'h0000_00FF);
      csr_write(reg_addr(tsfbc_pkg::REG_DECODE_MODE), 32'h0000_0001);
      csr_write(reg_addr(tsfbc_pkg::REG_FIRST_MUL),   32'h0000_FFFF);
      csr_write(reg_addr(tsfbc_pkg::REG_FIRST_ADD),   32'h0000_FFFF);
      csr_write(reg_addr(tsfbc_pkg::REG_SECOND_MUL),  32'h0000_FFFF);
      csr_write(reg_addr(tsfbc_pkg::REG_SECOND_ADD),  32'h0000_FFFF);
      csr_write(UNMAPPED_ADDR,                        32'hFFFF_FFFF);
      settings_used++;
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b1);
      // fresh message under the all-ones settings, decoding
      send_beat(8'h00, 1'b0);
      send_beat(8'h7F, 1'b0);
      send_beat(8'hFF, 1'b1);
      drain();
      // seed_byte above seed_word: the second key wraps below zero;
      // zero multipliers and addends collapse the key feedback
      csr_write(reg_addr(tsfbc_pkg::REG_SEED_WORD),   32'h0000_0000);
      csr_write(reg_addr(tsfbc_pkg::REG_FIRST_MUL),   32'h0000_0000);
      csr_write(reg_addr(tsfbc_pkg::REG_FIRST_ADD),   32'h0000_0000);
      csr_write(reg_addr(tsfbc_pkg::REG_SECOND_MUL),  32'h0000_0000);
      csr_write(reg_addr(tsfbc_pkg::REG_SECOND_ADD),  32'h0000_0000);
      csr_write(reg_addr(tsfbc_pkg::REG_DECODE_MODE), 32'h0000_0000);
      settings_used++;
      send_beat(8'hA5, 1'b0);
      send_beat(8'h5A, 1'b1);
      send_beat(8'hFF, 1'b1);
      drain();

      // --- random: a fresh setting per phase, idling pattern per third ---
      for (int phase = 0; phase < N_PHASES; phase++) begin
         if (phase < N_PHASES / 3) begin
            req_idle_pct = 12;
            rsp_idle_pct = 58;
         end else if (phase < 2 * N_PHASES / 3) begin
            req_idle_pct = 58;
            rsp_idle_pct = 12;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         random_settings();
         phase_beats = 0;
         hold_at     = $urandom_range(5, 40);
         while (phase_beats < PHASE_BEATS) begin
            // mostly short messages, now and then a long one
            msg_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 8);
            // the last message of a phase is sometimes left open, so the
            // next setting is written in the middle of a message
            close_msg = (phase_beats + msg_len < PHASE_BEATS) ||
                        ($urandom_range(0, 3) != 0);
            for (int i = 0; i < msg_len; i++) begin
               // receiver stops for a long stretch while beats keep coming,
               // filling the pipe until req_tready drops
               if (phase_beats == hold_at) hold_requests++;
               send_beat(8'($urandom()), close_msg && (i == msg_len - 1));
               phase_beats++;
            end
         end
         drain();
      end

      $display("Ran %0d beats in %0d closed messages over %0d register settings,",
               beats_sent, messages_sent, settings_used);
      $display("both directions, with idling on both sides; %0d responses checked.",
               checked_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
